// ===== src/ipt_pkg.sv =====
package ipt_pkg;

    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int CLAMP_W  = 10;
    localparam int TORQUE_W = 11;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int D1_W     = ERR_W + 1;
    localparam int D2_W     = ERR_W + 2;
    localparam int PP_W     = GAIN_W + 1 + D1_W;
    localparam int PI_W     = GAIN_W + 1 + ERR_W;
    localparam int PD_W     = GAIN_W + 1 + D2_W;
    localparam int INC_W    = PD_W + 2;
    localparam int ACC_W    = INC_W + 1;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int TORQUE_LIMIT = 1000;
    localparam logic signed [TORQUE_W-1:0] TORQUE_RESET = -11'sd250;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET      = 16'd21760;
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET      = 16'd640;
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET      = 16'd2048;
    localparam logic [CLAMP_W-1:0] DRIVE_LIMIT_RESET = 10'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 2'd0,
        REG_GAIN_I      = 2'd1,
        REG_GAIN_D      = 2'd2,
        REG_DRIVE_LIMIT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

endpackage

// ===== src/incremental_pid_torque_core.sv =====
// Incremental PID torque controller. Each input word carries a target and a measured
// speed in signed Q8.8; the block keeps the last two speed errors and a stored torque,
// adds the Q22.16 increment kp*(e-e1) + ki*e + kd*(e-2*e1+e2) to it, saturates at
// +/-1000 and truncates toward zero, and emits that torque clamped to +/- the drive limit.
// One word is accepted per cycle while m_ready does not hold back the output. The error
// differences are registered on acceptance; the three gain multipliers, the sum of the
// products, the torque accumulation loop and the output clamp then each have a register.
// The accumulation loop (a wide add followed by saturation) and the error history are the
// feedback paths. The user writes gains and the drive limit through the configuration port
// only while no word is in flight; the block itself does not enforce this.
module incremental_pid_torque_core (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [ipt_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [ipt_pkg::GAIN_W-1:0]                cfg_wdata,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [ipt_pkg::SPEED_W-1:0]        s_target_speed,
    input  logic signed [ipt_pkg::SPEED_W-1:0]        s_measured_speed,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [ipt_pkg::TORQUE_W-1:0]       m_drive_torque
);
    import ipt_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(TORQUE_LIMIT * (2 ** FRAC_W));

    gains_t               gains_reg;
    logic [CLAMP_W-1:0]   drive_limit_reg;

    logic                       inc_valid, inc_ready;
    logic signed [INC_W-1:0]    inc;

    logic                          acc_valid_reg, acc_ready, out_ready;
    logic signed [TORQUE_W-1:0]    torque_accum_reg, torque_next;
    logic signed [ACC_W-1:0]       acc_sum, acc_sat;
    logic signed [TORQUE_W-1:0]    lim, drive_next;
    logic                          m_valid_reg;
    logic signed [TORQUE_W-1:0]    m_drive_torque_reg;

    ipt_increment u_increment (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .gains       (gains_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_target   (s_target_speed),
        .in_measured (s_measured_speed),
        .out_valid   (inc_valid),
        .out_ready   (inc_ready),
        .out_inc     (inc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.kp    <= GAIN_P_RESET;
            gains_reg.ki    <= GAIN_I_RESET;
            gains_reg.kd    <= GAIN_D_RESET;
            drive_limit_reg <= DRIVE_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:      gains_reg.kp    <= cfg_wdata;
                REG_GAIN_I:      gains_reg.ki    <= cfg_wdata;
                REG_GAIN_D:      gains_reg.kd    <= cfg_wdata;
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign acc_ready = !acc_valid_reg || out_ready;
    assign inc_ready = acc_ready;

    // The sum is saturated first, then divided by 2^16 rounding toward zero.
    always_comb begin
        acc_sum = (ACC_W'(torque_accum_reg) <<< FRAC_W) + ACC_W'(inc);
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI;
        end else if (acc_sum < -ACC_HI) begin
            acc_sat = -ACC_HI;
        end else begin
            acc_sat = acc_sum;
        end
        torque_next = TORQUE_W'(acc_sat[ACC_W-1:FRAC_W])
                    + TORQUE_W'(acc_sat[ACC_W-1] && (acc_sat[FRAC_W-1:0] != '0));
    end

    always_comb begin
        lim = $signed({1'b0, drive_limit_reg});
        if (torque_accum_reg > lim) begin
            drive_next = lim;
        end else if (torque_accum_reg < -lim) begin
            drive_next = -lim;
        end else begin
            drive_next = torque_accum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
            torque_accum_reg <= TORQUE_RESET;
        end else begin
            if (acc_ready) begin
                acc_valid_reg <= inc_valid;
            end
            if (out_ready) begin
                m_valid_reg <= acc_valid_reg;
            end
            if (inc_valid && acc_ready) begin
                torque_accum_reg <= torque_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_valid_reg && out_ready) begin
            m_drive_torque_reg <= drive_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive_torque = m_drive_torque_reg;

    a_torque_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (torque_accum_reg <= 11'sd1000) && (torque_accum_reg >= -11'sd1000))
        else $error("Stored torque left its saturation range.");

    a_reset_torque: assert property (@(posedge aclk)
        $past(!aresetn) |-> (torque_accum_reg == TORQUE_RESET))
        else $error("Stored torque did not take its reset value.");

    a_drive_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(cfg_we)) |->
            (m_drive_torque <= $signed({1'b0, drive_limit_reg}))
            && (m_drive_torque >= -$signed({1'b0, drive_limit_reg})))
        else $error("Drive torque exceeds the clamp magnitude.");

    a_accum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(inc_valid && acc_ready) |=> $stable(torque_accum_reg))
        else $error("Stored torque changed without an increment word.");

endmodule

// ===== src/ipt_increment.sv =====
module ipt_increment (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  ipt_pkg::gains_t                           gains,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [ipt_pkg::SPEED_W-1:0]        in_target,
    input  logic signed [ipt_pkg::SPEED_W-1:0]        in_measured,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [ipt_pkg::INC_W-1:0]          out_inc
);
    import ipt_pkg::*;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    logic signed [ERR_W-1:0] prev_error_reg, prev_prev_error_reg;
    logic signed [ERR_W-1:0] err_next, err_reg;
    logic signed [D1_W-1:0]  d1_next, d1_reg;
    logic signed [D2_W-1:0]  d2_next, d2_reg;

    logic signed [PP_W-1:0]  pp_next, pp_reg;
    logic signed [PI_W-1:0]  pi_next, pi_reg;
    logic signed [PD_W-1:0]  pd_next, pd_reg;
    logic signed [INC_W-1:0] inc_next, inc_reg;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        err_next = ERR_W'(in_measured) - ERR_W'(in_target);
        d1_next  = D1_W'(err_next) - D1_W'(prev_error_reg);
        d2_next  = D2_W'(err_next) - (D2_W'(prev_error_reg) <<< 1)
                 + D2_W'(prev_prev_error_reg);
        pp_next  = $signed({1'b0, gains.kp}) * d1_reg;
        pi_next  = $signed({1'b0, gains.ki}) * err_reg;
        pd_next  = $signed({1'b0, gains.kd}) * d2_reg;
        inc_next = INC_W'(pp_reg) + INC_W'(pi_reg) + INC_W'(pd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg        <= 1'b0;
            s2_valid_reg        <= 1'b0;
            s3_valid_reg        <= 1'b0;
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (in_valid && s1_ready) begin
                prev_error_reg      <= err_next;
                prev_prev_error_reg <= prev_error_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s1_ready) begin
            err_reg <= err_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
        end
        if (s1_valid_reg && s2_ready) begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
        if (s2_valid_reg && s3_ready) begin
            inc_reg <= inc_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_inc   = inc_reg;

endmodule

// ===== tb/tb_incremental_pid_torque_core.sv =====
`timescale 1ns / 100ps

module tb_incremental_pid_torque_core;

    import ipt_pkg::*;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic signed [SPEED_W-1:0] measured;
    } speed_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    cfg_reg_t cfg_index = REG_GAIN_P;
    logic [GAIN_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SPEED_W-1:0] s_target_speed = '0;
    logic signed [SPEED_W-1:0] s_measured_speed = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [TORQUE_W-1:0] m_drive_torque;

    incremental_pid_torque_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_torque   (m_drive_torque)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Controller state and registers as the block should hold them.
    logic [GAIN_W-1:0] kp_q = GAIN_P_RESET;
    logic [GAIN_W-1:0] ki_q = GAIN_I_RESET;
    logic [GAIN_W-1:0] kd_q = GAIN_D_RESET;
    logic [CLAMP_W-1:0] torque_cap = DRIVE_LIMIT_RESET;
    int torque_sum = int'(TORQUE_RESET);
    longint err_last = 0;
    longint err_prior = 0;

    speed_word_t pending_words[$];
    logic signed [TORQUE_W-1:0] torque_expected[$];
    speed_word_t next_word;
    logic word_taken = 1'b0;
    logic signed [TORQUE_W-1:0] torque_want;

    int send_gap_pct = 22;
    int recv_gap_pct = 56;
    int errors = 0;
    int words_sent = 0;
    int torques_checked = 0;
    int rail_hits = 0;
    int cap_hits = 0;
    int gain_settings = 1;

    function automatic logic signed [TORQUE_W-1:0] predict_drive_torque(
        input logic signed [SPEED_W-1:0] tgt,
        input logic signed [SPEED_W-1:0] meas
    );
        longint e;
        longint d1;
        longint d2;
        longint inc;
        longint acc;
        longint hi;
        int lim;
        int o;
        e = longint'(meas) - longint'(tgt);
        d1 = e - err_last;
        d2 = e - 2 * err_last + err_prior;
        inc = longint'(kp_q) * d1 + longint'(ki_q) * e + longint'(kd_q) * d2;
        acc = longint'(torque_sum) * 65536 + inc;
        hi = longint'(TORQUE_LIMIT) * 65536;
        if (acc > hi) begin
            acc = hi;
        end else if (acc < -hi) begin
            acc = -hi;
        end
        torque_sum = int'(acc / 65536);
        if (torque_sum == TORQUE_LIMIT || torque_sum == -TORQUE_LIMIT) begin
            rail_hits++;
        end
        err_prior = err_last;
        err_last = e;
        lim = int'(torque_cap);
        o = torque_sum;
        if (o > lim) begin
            o = lim;
            cap_hits++;
        end else if (o < -lim) begin
            o = -lim;
            cap_hits++;
        end
        return o[TORQUE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            torque_expected.push_back(predict_drive_torque(s_target_speed, s_measured_speed));
            words_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (torque_expected.size() == 0) begin
                $error("drive_torque word %0d arrived with nothing expected", m_drive_torque);
                errors++;
            end else begin
                torque_want = torque_expected.pop_front();
                torques_checked++;
                if (m_drive_torque !== torque_want) begin
                    $error("drive_torque mismatch: expected %0d, got %0d",
                           torque_want, m_drive_torque);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                next_word = pending_words.pop_front();
                s_target_speed <= next_word.target;
                s_measured_speed <= next_word.measured;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_gap_pct);
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_GAIN_P: kp_q = data;
            REG_GAIN_I: ki_q = data;
            REG_GAIN_D: kd_q = data;
            REG_DRIVE_LIMIT: torque_cap = data[CLAMP_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas);
        speed_word_t w;
        w.target = tgt;
        w.measured = meas;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || torque_expected.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r < 4) begin
            return GAIN_W'($urandom);
        end
        return GAIN_W'($urandom_range(0, 4095));
    endfunction

    initial begin
        int r;
        int cap;
        logic [SPEED_W-1:0] tgt;
        logic [SPEED_W-1:0] meas;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_word(16'sd0, 16'sd0);
        push_word(16'sd0, 16'sd256);
        push_word(16'h8000, 16'h7fff);
        push_word(16'h8000, 16'h7fff);
        push_word(16'h7fff, 16'h8000);
        push_word(16'h8000, 16'h7fff);
        push_word(16'h7fff, 16'h7fff);
        push_word(16'h8000, 16'h8000);
        push_word(16'sd1, 16'sd0);
        push_word(16'sd0, 16'sd1);
        wait_drained();

        // A zero clamp holds every output at zero while the state keeps moving.
        write_reg(REG_DRIVE_LIMIT, 16'd0);
        push_word(16'h8000, 16'h7fff);
        push_word(16'h7fff, 16'h8000);
        push_word(16'sd100, 16'sd0);
        wait_drained();

        // Largest gains; the clamp above the rail passes the stored torque through,
        // and the upper write data bits are dropped.
        write_reg(REG_GAIN_P, 16'hffff);
        write_reg(REG_GAIN_I, 16'hffff);
        write_reg(REG_GAIN_D, 16'hffff);
        write_reg(REG_DRIVE_LIMIT, 16'hffff);
        push_word(16'h7fff, 16'h8000);
        push_word(16'h8000, 16'h7fff);
        push_word(16'sd0, 16'sd0);
        wait_drained();

        write_reg(REG_GAIN_P, 16'd0);
        write_reg(REG_GAIN_I, 16'd0);
        write_reg(REG_GAIN_D, 16'd0);
        write_reg(REG_DRIVE_LIMIT, 16'd1000);
        push_word(16'h8000, 16'h7fff);
        push_word(16'sd5, 16'sd3);
        wait_drained();
        gain_settings += 3;

        for (int phase = 0; phase < 16; phase++) begin
            if (phase == 6) begin
                send_gap_pct = 56;
                recv_gap_pct = 22;
            end else if (phase == 11) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            r = $urandom_range(0, 5);
            cap = (r == 0) ? 0 : (r == 1) ? 1000 : (r == 2) ? 1023 : $urandom_range(0, 1023);
            write_reg(REG_DRIVE_LIMIT, {6'($urandom), 10'(cap)});
            gain_settings++;
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(0, 9);
                tgt = SPEED_W'($urandom);
                if (r < 6) begin
                    meas = tgt + SPEED_W'($urandom_range(0, 1023)) - 16'd512;
                end else if (r < 8) begin
                    meas = tgt + SPEED_W'($urandom_range(0, 16383)) - 16'd8192;
                end else begin
                    meas = SPEED_W'($urandom);
                end
                push_word(tgt, meas);
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (torque_expected.size() != 0) begin
            $error("%0d drive_torque words never arrived", torque_expected.size());
            errors++;
        end
        $display("Sent %0d speed words under %0d gain and clamp settings.",
                 words_sent, gain_settings);
        $display("Checked %0d torque words: %0d at the +/-1000 rail, %0d cut by the limit.",
                 torques_checked, rail_hits, cap_hits);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Run timed out.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
